// ----- rtl/core/tes_pkg.sv -----
`default_nettype none
package tes_pkg;

  localparam int NODE_INDEX_BITS_DEF = 20;
  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;   // coordinate difference
  localparam int PROD_W  = 2 * DIFF_W;    // product of two differences
  localparam int SUM_W   = PROD_W + 1;    // sum of two products
  localparam int QUOT_W  = 33;            // quotient bits before saturation

  // vertex pair (p, q) of edge i: b_i = y_p - y_q, c_i = x_q - x_p
  localparam logic [1:0] EDGE_P [3] = '{2'd1, 2'd2, 2'd0};
  localparam logic [1:0] EDGE_Q [3] = '{2'd2, 2'd0, 2'd1};

  localparam logic [1:0] LAST_IDX = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/core/tes_in_if.sv -----
`default_nettype none
interface tes_in_if #(
  parameter int NODE_INDEX_BITS = tes_pkg::NODE_INDEX_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic [NODE_INDEX_BITS-1:0]          node_a;
  logic [NODE_INDEX_BITS-1:0]          node_b;
  logic [NODE_INDEX_BITS-1:0]          node_c;
  logic signed [tes_pkg::COORD_W-1:0]  ax;
  logic signed [tes_pkg::COORD_W-1:0]  ay;
  logic signed [tes_pkg::COORD_W-1:0]  bx;
  logic signed [tes_pkg::COORD_W-1:0]  by_coord;
  logic signed [tes_pkg::COORD_W-1:0]  cx;
  logic signed [tes_pkg::COORD_W-1:0]  cy;

  modport source (output valid, node_a, node_b, node_c, ax, ay, bx, by_coord, cx, cy,
                  input ready);
  modport sink   (input valid, node_a, node_b, node_c, ax, ay, bx, by_coord, cx, cy,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/core/tes_out_if.sv -----
`default_nettype none
interface tes_out_if #(
  parameter int NODE_INDEX_BITS = tes_pkg::NODE_INDEX_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic [NODE_INDEX_BITS-1:0]          row_node;
  logic [NODE_INDEX_BITS-1:0]          col_node;
  logic signed [tes_pkg::COORD_W-1:0]  stiffness;
  logic                                last_entry;
  logic                                degenerate;

  modport source (output valid, row_node, col_node, stiffness, last_entry, degenerate,
                  input ready);
  modport sink   (input valid, row_node, col_node, stiffness, last_entry, degenerate,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/core/triangle_element_stiffness.sv -----
`default_nettype none
// channel | dir | payload                                             | transfer
// elem    | in  | node_a..c, ax, ay, bx, by_coord, cx, cy             | valid & ready
// entry   | out | row_node, col_node, stiffness, last_entry, degenerate | valid & ready
//
// one entry per cycle unless entry stalls, nine entries per element, set by the entry sequencer
// stages in order: 4 element stages, 1 sequencer register, 4 entry stages, 34 divider stages,
// 1 output register
// the quotient is a pipelined restoring divider, one quotient bit per stage
// rst (synchronous) clears all valid bits and the sequencer
// a stall on entry freezes every stage; nothing is lost or repeated
module triangle_element_stiffness #(
  parameter int NODE_INDEX_BITS = tes_pkg::NODE_INDEX_BITS_DEF,
  parameter int COORD_FRAC_BITS = tes_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tes_in_if.sink     elem,
  tes_out_if.source  entry
);

  localparam int DW  = tes_pkg::DIFF_W;
  localparam int PW  = tes_pkg::PROD_W;
  localparam int SW  = tes_pkg::SUM_W;
  localparam int QB  = tes_pkg::QUOT_W;
  localparam int DDW = SW + 1;                      // divisor 2*|det|
  localparam int RW  = DDW + QB + COORD_FRAC_BITS;  // remainder width
  localparam int NB  = NODE_INDEX_BITS;
  localparam int CW  = tes_pkg::COORD_W;

  typedef struct packed {
    logic [NB-1:0] row;
    logic [NB-1:0] col;
    logic          last;
    logic          degen;
    logic          neg;
  } meta_t;

  // shared stall: the output register gates every stage; front_move also waits on the sequencer
  logic out_valid;
  logic advance;
  logic front_move;
  assign advance = !out_valid || entry.ready;

  // ---------------- element stages ----------------
  logic                 e1_valid, e2_valid, e3_valid, e4_valid;
  logic [NB-1:0]        e1_node [3];
  logic [NB-1:0]        e2_node [3];
  logic [NB-1:0]        e3_node [3];
  logic [NB-1:0]        e4_node [3];
  logic signed [CW-1:0] e1_x [3];
  logic signed [CW-1:0] e1_y [3];
  logic signed [DW-1:0] e2_b [3];
  logic signed [DW-1:0] e2_c [3];
  logic signed [DW-1:0] e3_b [3];
  logic signed [DW-1:0] e3_c [3];
  logic signed [DW-1:0] e4_b [3];
  logic signed [DW-1:0] e4_c [3];
  logic signed [PW-1:0] e3_pd1, e3_pd2;
  logic signed [SW-1:0] e4_det;

  assign elem.ready = front_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
      e2_valid <= 1'b0;
      e3_valid <= 1'b0;
      e4_valid <= 1'b0;
    end else if (front_move) begin
      e1_valid <= elem.valid;
      e2_valid <= e1_valid;
      e3_valid <= e2_valid;
      e4_valid <= e3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_move) begin
      e1_node[0] <= elem.node_a;
      e1_node[1] <= elem.node_b;
      e1_node[2] <= elem.node_c;
      e1_x[0] <= elem.ax;
      e1_y[0] <= elem.ay;
      e1_x[1] <= elem.bx;
      e1_y[1] <= elem.by_coord;
      e1_x[2] <= elem.cx;
      e1_y[2] <= elem.cy;
      for (int i = 0; i < 3; i++) begin
        // edge terms
        e2_b[i] <= DW'(e1_y[tes_pkg::EDGE_P[i]]) - DW'(e1_y[tes_pkg::EDGE_Q[i]]);
        e2_c[i] <= DW'(e1_x[tes_pkg::EDGE_Q[i]]) - DW'(e1_x[tes_pkg::EDGE_P[i]]);
        e2_node[i] <= e1_node[i];
        e3_b[i] <= e2_b[i];
        e3_c[i] <= e2_c[i];
        e3_node[i] <= e2_node[i];
        e4_b[i] <= e3_b[i];
        e4_c[i] <= e3_c[i];
        e4_node[i] <= e3_node[i];
      end
      // det = (x1-x0)(y2-y0) - (x2-x0)(y1-y0) = c2*b1 - c1*b2
      e3_pd1 <= e2_c[2] * e2_b[1];
      e3_pd2 <= e2_c[1] * e2_b[2];
      e4_det <= SW'(e3_pd1) - SW'(e3_pd2);
    end
  end

  // ---------------- entry sequencer ----------------
  logic                 seq_valid;
  logic [1:0]           seq_i, seq_j;
  logic                 seq_last;
  logic [NB-1:0]        seq_node [3];
  logic signed [DW-1:0] seq_b [3];
  logic signed [DW-1:0] seq_c [3];
  logic [SW-1:0]        seq_adet;
  logic                 seq_degen;

  assign seq_last   = (seq_i == tes_pkg::LAST_IDX) && (seq_j == tes_pkg::LAST_IDX);
  assign front_move = advance && (!seq_valid || seq_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_valid <= 1'b0;
      seq_i     <= '0;
      seq_j     <= '0;
    end else if (front_move) begin
      seq_valid <= e4_valid;
      seq_i     <= '0;
      seq_j     <= '0;
    end else if (advance && seq_valid) begin
      if (seq_j == tes_pkg::LAST_IDX) begin
        seq_j <= '0;
        seq_i <= seq_i + 2'd1;
      end else begin
        seq_j <= seq_j + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (front_move) begin
      seq_node  <= e4_node;
      seq_b     <= e4_b;
      seq_c     <= e4_c;
      seq_adet  <= e4_det[SW-1] ? SW'(-e4_det) : SW'(e4_det);
      seq_degen <= (e4_det == '0);
    end
  end

  // ---------------- entry stages ----------------
  logic                 p1_valid, p2_valid, p3_valid, p4_valid;
  meta_t                p1_meta, p2_meta, p3_meta, p4_meta;
  logic signed [PW-1:0] p1_pb, p1_pc;
  logic [SW-1:0]        p1_adet, p2_adet, p3_adet;
  logic signed [SW-1:0] p2_num;
  logic [SW-1:0]        p3_mag;
  logic [RW-1:0]        p4_n;
  logic [DDW-1:0]       p4_d;
  meta_t                seq_meta;

  always_comb begin
    seq_meta.row   = seq_node[seq_i];
    seq_meta.col   = seq_node[seq_j];
    seq_meta.last  = seq_last;
    seq_meta.degen = seq_degen;
    seq_meta.neg   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else if (advance) begin
      p1_valid <= seq_valid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_meta <= seq_meta;
      p1_pb   <= seq_b[seq_i] * seq_b[seq_j];
      p1_pc   <= seq_c[seq_i] * seq_c[seq_j];
      p1_adet <= seq_adet;
      p2_meta <= p1_meta;
      p2_num  <= SW'(p1_pb) + SW'(p1_pc);
      p2_adet <= p1_adet;
      // sign of the numerator joins the entry here
      p3_meta     <= {p2_meta.row, p2_meta.col, p2_meta.last, p2_meta.degen, p2_num[SW-1]};
      p3_mag      <= p2_num[SW-1] ? SW'(-p2_num) : SW'(p2_num);
      p3_adet     <= p2_adet;
      p4_meta <= p3_meta;
      // rounded quotient: (|num|<<F + |det|) / (2|det|)
      p4_n    <= (RW'(p3_mag) << COORD_FRAC_BITS) + RW'(p3_adet);
      p4_d    <= {p3_adet, 1'b0};
    end
  end

  // ---------------- divider, one quotient bit per stage ----------------
  logic           dv_valid [QB+1];
  meta_t          dv_meta  [QB+1];
  logic [RW-1:0]  dv_r     [QB+1];
  logic [DDW-1:0] dv_d     [QB+1];
  logic [QB-1:0]  dv_q     [QB+1];
  logic           dv_ovf   [QB+1];

  // first stage only flags a quotient at or above 2^QB
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (advance) begin
      dv_valid[0] <= p4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dv_meta[0] <= p4_meta;
      dv_r[0]    <= p4_n;
      dv_d[0]    <= p4_d;
      dv_q[0]    <= '0;
      dv_ovf[0]  <= (p4_n >= (RW'(p4_d) << QB));
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_div
    localparam int K = QB - s;
    logic [RW-1:0] sub_d;
    logic          take;
    assign sub_d = RW'(dv_d[s-1]) << K;
    assign take  = (dv_r[s-1] >= sub_d);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[s] <= 1'b0;
      end else if (advance) begin
        dv_valid[s] <= dv_valid[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dv_meta[s] <= dv_meta[s-1];
        dv_d[s]    <= dv_d[s-1];
        dv_ovf[s]  <= dv_ovf[s-1];
        dv_r[s]    <= take ? (dv_r[s-1] - sub_d) : dv_r[s-1];
        dv_q[s]    <= take ? (dv_q[s-1] | (QB'(1) << K)) : dv_q[s-1];
      end
    end
  end

  // ---------------- saturation and output register ----------------
  meta_t          fin_meta;
  logic [QB-1:0]  fin_lim;
  logic [QB-1:0]  fin_mag;
  logic [CW-1:0]  fin_val;

  assign fin_meta = dv_meta[QB];
  assign fin_lim  = fin_meta.neg ? (QB'(1) << (CW-1)) : ((QB'(1) << (CW-1)) - QB'(1));
  assign fin_mag  = (dv_ovf[QB] || (dv_q[QB] > fin_lim)) ? fin_lim : dv_q[QB];

  always_comb begin
    if (fin_meta.degen) begin
      fin_val = '0;
    end else if (fin_meta.neg) begin
      fin_val = -fin_mag[CW-1:0];
    end else begin
      fin_val = fin_mag[CW-1:0];
    end
  end

  logic [NB-1:0]        out_row, out_col;
  logic signed [CW-1:0] out_val;
  logic                 out_last, out_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= dv_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_row   <= fin_meta.row;
      out_col   <= fin_meta.col;
      out_val   <= fin_val;
      out_last  <= fin_meta.last;
      out_degen <= fin_meta.degen;
    end
  end

  assign entry.valid      = out_valid;
  assign entry.row_node   = out_row;
  assign entry.col_node   = out_col;
  assign entry.stiffness  = out_val;
  assign entry.last_entry = out_last;
  assign entry.degenerate = out_degen;

  // ---------------- assertions ----------------
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_degen |-> out_val == '0)
    else $error("degenerate entry with nonzero stiffness");

  a_seq_range: assert property (@(posedge clk) disable iff (rst)
    seq_valid |-> seq_i != 2'd3 && seq_j != 2'd3)
    else $error("sequencer index out of range");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    elem.valid && elem.ready |-> !seq_valid || seq_last)
    else $error("element taken while sequencer busy");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !seq_valid)
    else $error("valid bits not cleared by reset");

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB        = tes_pkg::NODE_INDEX_BITS_DEF;
  localparam int FB        = tes_pkg::COORD_FRAC_BITS_DEF;
  localparam int N_RANDOM  = 100;
  localparam int DRAIN     = 60;     // settling time after the last expected entry
  localparam int WDOG_MAX  = 3000;   // idle cycles before giving up
  localparam int HOLD_LEN  = 300;    // long receiver hold-off
  localparam int HOLD_AT   = 90;     // entry count that triggers the hold-off
  localparam int PAUSE_AT  = 60;     // random element after which the sender drains

  localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;

  // one triangle element as offered on the input channel
  typedef struct packed {
    logic [NB-1:0]      na, nb, nc;
    logic signed [31:0] ax, ay, bx, by, cx, cy;
  } tri_t;

  // one stiffness triplet as expected on the output channel
  typedef struct packed {
    logic [NB-1:0]      row, col;
    logic signed [31:0] k;
    logic               last, degen;
  } triplet_t;

  // directed row: when zero_area is set the expected result is forced to zero and degenerate
  typedef struct packed {
    tri_t t;
    logic zero_area;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tes_in_if  #(.NODE_INDEX_BITS(NB)) elem ();
  tes_out_if #(.NODE_INDEX_BITS(NB)) entry ();

  triangle_element_stiffness #(
    .NODE_INDEX_BITS(NB),
    .COORD_FRAC_BITS(FB)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .elem  (elem),
    .entry (entry)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triplet_t stiff_q[$];       // triplets still to come, oldest first
  int       errors     = 0;
  int       n_elems    = 0;
  int       n_entries  = 0;
  int       n_degen    = 0;
  int       n_sat      = 0;
  int       idle_cnt   = 0;

  // signed product of two 33-bit differences, exact in 128 bits
  function automatic logic signed [127:0] wmul(logic signed [32:0] a, logic signed [32:0] b);
    logic signed [127:0] wa, wb;
    wa = 128'(a);
    wb = 128'(b);
    return wa * wb;
  endfunction

  // nine triplets of the local stiffness matrix, row-major
  function automatic void predict_stiffness(tri_t t, logic force_zero);
    logic signed [32:0]  xs [3];
    logic signed [32:0]  ys [3];
    logic signed [32:0]  eb [3];
    logic signed [32:0]  ec [3];
    logic signed [127:0] det, num;
    logic [127:0]        adet, mag, quo, lim;
    logic                degen, neg;
    logic [31:0]         val;
    int                  p, q;
    triplet_t            tr;
    logic [NB-1:0]       nodes [3];
    nodes[0] = t.na; nodes[1] = t.nb; nodes[2] = t.nc;
    xs[0] = 33'(t.ax); ys[0] = 33'(t.ay);
    xs[1] = 33'(t.bx); ys[1] = 33'(t.by);
    xs[2] = 33'(t.cx); ys[2] = 33'(t.cy);
    for (int i = 0; i < 3; i++) begin
      p = (i + 1) % 3;
      q = (i + 2) % 3;
      eb[i] = ys[p] - ys[q];
      ec[i] = xs[q] - xs[p];
    end
    det   = wmul(xs[1] - xs[0], ys[2] - ys[0]) - wmul(xs[2] - xs[0], ys[1] - ys[0]);
    adet  = det[127] ? -det : det;
    degen = (adet == 0);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        val = '0;
        if (!degen) begin
          num = wmul(eb[i], eb[j]) + wmul(ec[i], ec[j]);
          neg = num[127];
          mag = (neg ? -num : num) << FB;
          // round half away from zero: (|num|<<F + |det|) / (2|det|)
          quo = (mag + adet) / (adet << 1);
          lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
          if (quo > lim) begin
            quo = lim;
            n_sat++;
          end
          val = neg ? 32'(-quo) : 32'(quo);
        end
        tr.row   = nodes[i];
        tr.col   = nodes[j];
        tr.k     = force_zero ? 32'sd0 : val;
        tr.last  = (i == 2) && (j == 2);
        tr.degen = force_zero ? 1'b1 : degen;
        stiff_q.insert(stiff_q.size(), tr);
      end
    end
    if (degen || force_zero) n_degen++;
  endfunction

  // directed table: extremes, zero area, collinear, slivers, unit triangles
  row_t dir_rows [] = '{
    '{'{20'd0, 20'd1, 20'd2, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1},
    '{'{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1},
    '{'{20'h12345, 20'hFFFFF, 20'h0, CMIN, CMIN, 32'sd0, 32'sd0, CMAX, CMAX}, 1'b1},
    '{'{20'd7, 20'd8, 20'd9, 32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, ONE}, 1'b0},
    '{'{20'd9, 20'd8, 20'd7, 32'sd0, 32'sd0, 32'sd0, ONE, ONE, 32'sd0}, 1'b0},
    '{'{20'hFFFFF, 20'h0, 20'h55555, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd1}, 1'b0},
    '{'{20'hAAAAA, 20'h55555, 20'hFFFFF, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX}, 1'b0},
    '{'{20'd1, 20'd2, 20'd3, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b0},
    '{'{20'd4, 20'd5, 20'd6, CMIN, 32'sd0, CMAX, 32'sd1, 32'sd0, 32'sd0}, 1'b0},
    '{'{20'd4, 20'd5, 20'd6, CMIN, CMAX, CMAX, CMIN, 32'sd0, 32'sd0}, 1'b0},
    '{'{20'd3, 20'd3, 20'd3, 32'sd0, 32'sd0, CMAX, 32'sd1, 32'sd1, 32'sd0}, 1'b0},
    '{'{20'd10, 20'd11, 20'd12, -ONE, -ONE, ONE, -ONE, 32'sd0, ONE}, 1'b0},
    '{'{20'd13, 20'd14, 20'd15, 32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd6}, 1'b1},
    '{'{20'd16, 20'd17, 20'd18, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX}, 1'b0},
    '{'{20'd19, 20'd20, 20'd21, 32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6}, 1'b1}
  };

  function automatic tri_t rand_tri();
    tri_t t;
    logic signed [31:0] dx, dy;
    int                 sel, m;
    t.na = NB'($urandom);
    t.nb = NB'($urandom);
    t.nc = NB'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      // full range: every coordinate bit toggles
      {t.ax, t.ay, t.bx, t.by, t.cx, t.cy} = {$urandom, $urandom, $urandom,
                                              $urandom, $urandom, $urandom};
    end else if (sel < 8) begin
      // mesh-like element: small coordinates near a random origin
      t.ax = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      t.ay = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      t.bx = t.ax + $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      t.by = t.ay + $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      t.cx = t.ax + $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      t.cy = t.ay + $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
    end else begin
      // collinear points or a repeated vertex: zero area
      dx = $signed($urandom_range(0, 32'hFFFF)) - 32'sh8000;
      dy = $signed($urandom_range(0, 32'hFFFF)) - 32'sh8000;
      m  = $urandom_range(0, 4);
      t.ax = $signed($urandom_range(0, 32'h0FFF_FFFF));
      t.ay = $signed($urandom_range(0, 32'h0FFF_FFFF));
      t.bx = t.ax + dx;
      t.by = t.ay + dy;
      t.cx = t.ax + dx * m;
      t.cy = t.ay + dy * m;
    end
    return t;
  endfunction

  // drive one element and wait for its transfer
  task automatic offer_element(tri_t t, logic force_zero);
    elem.node_a   <= t.na;
    elem.node_b   <= t.nb;
    elem.node_c   <= t.nc;
    elem.ax       <= t.ax;
    elem.ay       <= t.ay;
    elem.bx       <= t.bx;
    elem.by_coord <= t.by;
    elem.cx       <= t.cx;
    elem.cy       <= t.cy;
    elem.valid    <= 1'b1;
    do @(posedge clk); while (!elem.ready);
    predict_stiffness(t, force_zero);
    n_elems++;
  endtask

  // random sender gap: mostly none or short, now and then long
  task automatic sender_gap(bit quiet);
    int gap;
    gap = quiet ? 0 : ($urandom_range(0, 9) < 6 ? 0 :
                       ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3)
                                                 : $urandom_range(15, 60)));
    if (gap > 0) begin
      elem.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver: random stalls plus one long hold-off, counted here
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  rx_quiet  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      entry.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      entry.ready <= 1'b0;
    end else if (!hold_done && n_entries >= HOLD_AT) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_LEN;
      entry.ready <= 1'b0;
    end else if (rx_quiet) begin
      entry.ready <= 1'b1;
    end else begin
      // mostly ready, short stalls, rare longer ones via a run of lows
      entry.ready <= ($urandom_range(0, 99) < 75);
      if ($urandom_range(0, 199) == 0) hold_left <= $urandom_range(10, 40);
    end
  end

  // stretches of back-to-back readiness
  initial begin
    forever begin
      repeat ($urandom_range(200, 500)) @(posedge clk);
      rx_quiet = 1'b1;
      repeat ($urandom_range(50, 120)) @(posedge clk);
      rx_quiet = 1'b0;
    end
  end

  // output checker: compare each transfer with the oldest expected triplet
  always @(posedge clk) begin
    triplet_t exp_t;
    if (!rst && entry.valid && entry.ready) begin
      n_entries <= n_entries + 1;
      if (stiff_q.size() == 0) begin
        $display("%0t: unexpected entry row=%0d col=%0d k=%0d", $time,
                 entry.row_node, entry.col_node, entry.stiffness);
        errors++;
      end else begin
        exp_t = stiff_q.pop_front();
        if (entry.row_node !== exp_t.row) begin
          $display("%0t: row_node expected %0d actual %0d", $time, exp_t.row, entry.row_node);
          errors++;
        end
        if (entry.col_node !== exp_t.col) begin
          $display("%0t: col_node expected %0d actual %0d", $time, exp_t.col, entry.col_node);
          errors++;
        end
        if (entry.stiffness !== exp_t.k) begin
          $display("%0t: stiffness expected %0d actual %0d", $time, exp_t.k, entry.stiffness);
          errors++;
        end
        if (entry.last_entry !== exp_t.last) begin
          $display("%0t: last_entry expected %0b actual %0b", $time, exp_t.last,
                   entry.last_entry);
          errors++;
        end
        if (entry.degenerate !== exp_t.degen) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, exp_t.degen,
                   entry.degenerate);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (elem.valid && elem.ready) || (entry.valid && entry.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WDOG_MAX) begin
        $display("%0t: watchdog expired, %0d triplets outstanding", $time, stiff_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    elem.valid    = 1'b0;
    elem.node_a   = '0;
    elem.node_b   = '0;
    elem.node_c   = '0;
    elem.ax       = '0;
    elem.ay       = '0;
    elem.bx       = '0;
    elem.by_coord = '0;
    elem.cx       = '0;
    elem.cy       = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, back to back for the first four rows, then with random gaps
    foreach (dir_rows[r]) begin
      offer_element(dir_rows[r].t, dir_rows[r].zero_area);
      sender_gap(r < 4);
    end

    // random elements
    for (int n = 0; n < N_RANDOM; n++) begin
      offer_element(rand_tri(), 1'b0);
      if (n == PAUSE_AT) begin
        // drain the pipeline completely before going on
        elem.valid <= 1'b0;
        wait (stiff_q.size() == 0);
        @(posedge clk);
      end else begin
        sender_gap(n >= 20 && n < 40);
      end
    end
    elem.valid <= 1'b0;

    wait (stiff_q.size() == 0);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d elements, %0d triplets, %0d zero-area, %0d saturated entries",
             n_elems, n_entries, n_degen, n_sat);
    if (errors == 0 && stiff_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/tes_pkg.sv
rtl/core/tes_in_if.sv
rtl/core/tes_out_if.sv
rtl/core/triangle_element_stiffness.sv
bench/tb_top.sv
